>>> hw/rtl/kvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_pkg
// Shared types, constants and helpers of the bucketed key-value cache.
// ----------------------------------------------------------------------------
package kvc_pkg;

   localparam int unsigned NumBucketsDefault = 256;
   localparam int unsigned WaysDefault       = 4;
   localparam int unsigned ValueBytesDefault = 8;

   localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
   localparam logic [63:0] FnvPrime = 64'h00000100000001b3;
   localparam logic [63:0] KeyOnes  = 64'hffffffffffffffff;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_STALE  = 2'd2,
      OP_EVICT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_REJECT   = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_HASH,
      S_READ,
      S_DECIDE,
      S_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;  // write reset contents at the clear pointer
      logic load;        // capture request
      logic hash_step;   // one FNV byte round
      logic read;        // issue memory read of bucket
      logic decide;      // evaluate and write back
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic hash_done;
   } sts_type;

   // Mask of the low n bytes of a 64-bit word.
   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (n > 4'(i)) m[8*i +: 8] = 8'hff;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kvc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_req_if / kvc_rsp_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface kvc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [63:0] key;
   logic [63:0] value_in;
   logic [3:0]  value_length;
   logic [3:0]  read_capacity;
   modport source (output valid, operation, key, value_in, value_length,
                   read_capacity, input ready);
   modport sink   (input valid, operation, key, value_in, value_length,
                   read_capacity, output ready);
endinterface

interface kvc_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [63:0] value_out;
   logic [3:0]  length_out;
   logic [1:0]  status;
   logic [31:0] bucket_version;
   modport source (output valid, hit, value_out, length_out, status,
                   bucket_version, input ready);
   modport sink   (input valid, hit, value_out, length_out, status,
                   bucket_version, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kvc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module kvc_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  wr_addr,
   input  wire [Width-1:0]          wr_data,
   input  wire [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

>>> hw/rtl/kvc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_ctrl
// Sequencer: clear pass after reset, then hash, read, decide, respond.
// ----------------------------------------------------------------------------
module kvc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  wire kvc_pkg::sts_type  sts,
   output kvc_pkg::cmd_type       cmd
);
   kvc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= kvc_pkg::S_CLEAR;
      else       state_ff <= state_in;
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         kvc_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = kvc_pkg::S_IDLE;
         end
         kvc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kvc_pkg::S_HASH;
            end
         end
         kvc_pkg::S_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_done) state_in = kvc_pkg::S_READ;
         end
         kvc_pkg::S_READ: begin
            cmd.read = 1'b1;
            state_in = kvc_pkg::S_DECIDE;
         end
         kvc_pkg::S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = kvc_pkg::S_OUT;
         end
         kvc_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = kvc_pkg::S_IDLE;
         end
         default: state_in = kvc_pkg::S_IDLE;
      endcase
   end
endmodule

`default_nettype wire

>>> hw/rtl/kvc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvc_dp
// Datapath: byte-serial FNV hash, bucket row memories, way selection,
// write-back and result register.
// ----------------------------------------------------------------------------
module kvc_dp #(
   parameter int unsigned NumBuckets = kvc_pkg::NumBucketsDefault,
   parameter int unsigned Ways       = kvc_pkg::WaysDefault,
   parameter int unsigned ValueBytes = kvc_pkg::ValueBytesDefault
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire kvc_pkg::cmd_type  cmd,
   output kvc_pkg::sts_type       sts,
   input  wire [1:0]              req_operation,
   input  wire [63:0]             req_key,
   input  wire [63:0]             req_value_in,
   input  wire [3:0]              req_value_length,
   input  wire [3:0]              req_read_capacity,
   output logic                   rsp_hit,
   output logic [63:0]            rsp_value_out,
   output logic [3:0]             rsp_length_out,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_bucket_version
);
   localparam int unsigned BW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int unsigned WW = (Ways > 1) ? $clog2(Ways) : 1;
   // per way: key, tomb, stale, length, recency
   localparam int unsigned MetaW = 64 + 1 + 1 + 4 + 64;
   localparam int unsigned RowW  = Ways * MetaW + 32;
   localparam int unsigned ValW  = Ways * 64;
   localparam logic [3:0]  MaxLen = 4'(ValueBytes);

   // Request registers
   logic [1:0]  op_ff;
   logic [63:0] key_ff, vin_ff;
   logic [3:0]  vlen_ff, cap_ff;
   logic [63:0] hash_ff;
   logic [2:0]  hcnt_ff;
   logic        hlast_ff;
   logic [63:0] stamp_ff;
   logic [BW:0] clr_ff;
   logic        reserved, ins_ok;

   logic [63:0] hash_x;
   logic [63:0] hash_in;
   logic [BW-1:0] bucket;

   // FNV prime is 2^40 + 0x1b3: multiply as shifts and adds
   assign hash_x  = hash_ff ^ {56'd0, key_ff[8*hcnt_ff +: 8]};
   assign hash_in = (hash_x << 40) + (hash_x << 8) + (hash_x << 7) + (hash_x << 5)
                  + (hash_x << 4) + (hash_x << 1) + hash_x;
   assign bucket  = (NumBuckets > 1) ? BW'(hash_ff % 64'(NumBuckets)) : '0;

   assign sts.hash_done  = hlast_ff;
   assign sts.clear_done = (clr_ff == (BW+1)'(NumBuckets - 1));

   // Memories
   logic            row_we;
   logic [BW-1:0]   row_waddr;
   logic [RowW-1:0] row_wdata, row_rdata;
   logic            val_we;
   logic [ValW-1:0] val_wdata, val_rdata;

   kvc_ram #(.Width(RowW), .Depth(NumBuckets)) u_row (
      .clock(clock), .wr_en(row_we), .wr_addr(row_waddr),
      .wr_data(row_wdata), .rd_addr(bucket), .rd_data(row_rdata));

   kvc_ram #(.Width(ValW), .Depth(NumBuckets)) u_val (
      .clock(clock), .wr_en(val_we), .wr_addr(bucket),
      .wr_data(val_wdata), .rd_addr(bucket), .rd_data(val_rdata));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
         clr_ff   <= '0;
         hcnt_ff  <= '0;
         hlast_ff <= 1'b0;
      end else begin
         if (cmd.clear_step && !sts.clear_done) clr_ff <= clr_ff + 1'b1;
         if (cmd.load) begin
            hcnt_ff  <= '0;
            hlast_ff <= 1'b0;
         end else if (cmd.hash_step) begin
            hcnt_ff  <= hcnt_ff + 1'b1;
            hlast_ff <= (hcnt_ff == 3'd7);
         end
         if (cmd.decide && ins_ok) stamp_ff <= stamp_ff + 64'd1;
      end
   end

   // Request capture and hash rounds
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         key_ff  <= req_key;
         vin_ff  <= req_value_in;
         vlen_ff <= req_value_length;
         cap_ff  <= req_read_capacity;
         hash_ff <= kvc_pkg::FnvBasis;
      end else if (cmd.hash_step && !hlast_ff) begin
         hash_ff <= hash_in;
      end
   end

   // Way evaluation
   logic [63:0] wkey [Ways];
   logic        wtomb [Ways], wstale [Ways];
   logic [3:0]  wlen [Ways];
   logic [63:0] wrec [Ways];
   logic [31:0] ver;
   logic        found, frfound;
   logic [WW-1:0] fway, frway, lway, sel;
   logic [63:0] lstamp;
   kvc_pkg::op_type op;

   assign op = kvc_pkg::op_type'(op_ff);
   assign reserved = (key_ff == '0) || (key_ff == kvc_pkg::KeyOnes);
   assign ins_ok = !reserved && (op == kvc_pkg::OP_INSERT) && (vlen_ff <= MaxLen);
   assign ver = row_rdata[RowW-1 -: 32];

   always_comb begin
      for (int w = 0; w < Ways; w++) begin
         wkey[w]   = row_rdata[w*MetaW +: 64];
         wtomb[w]  = row_rdata[w*MetaW + 64];
         wstale[w] = row_rdata[w*MetaW + 65];
         wlen[w]   = row_rdata[w*MetaW + 66 +: 4];
         wrec[w]   = row_rdata[w*MetaW + 70 +: 64];
      end
      found = 1'b0; fway = '0;
      frfound = 1'b0; frway = '0;
      lway = '0; lstamp = wrec[0];
      for (int w = 0; w < Ways; w++) begin
         if (!found && !wtomb[w] && wkey[w] == key_ff) begin
            found = 1'b1; fway = WW'(w);
         end
         if (!frfound && (wtomb[w] || wkey[w] == '0)) begin
            frfound = 1'b1; frway = WW'(w);
         end
         if (wrec[w] < lstamp) begin
            lstamp = wrec[w]; lway = WW'(w);
         end
      end
      if (op == kvc_pkg::OP_INSERT)
         sel = found ? fway : (frfound ? frway : lway);
      else
         sel = fway;
   end

   // Write-back and result
   logic        hit_c;
   logic [3:0]  sz;
   logic        bump;
   logic [31:0] ver_new;

   always_comb begin
      hit_c = !reserved && op == kvc_pkg::OP_LOOKUP && found && !wstale[fway];
      sz    = (wlen[fway] > cap_ff) ? cap_ff : wlen[fway];
      bump  = ins_ok || (!reserved && found &&
              (op == kvc_pkg::OP_STALE || op == kvc_pkg::OP_EVICT));
      ver_new = ver + 32'(bump);

      row_we    = 1'b0;
      row_waddr = bucket;
      row_wdata = row_rdata;
      val_we    = 1'b0;
      val_wdata = val_rdata;
      if (cmd.clear_step) begin
         row_we    = 1'b1;
         row_waddr = clr_ff[BW-1:0];
         row_wdata = '0;
      end else if (cmd.decide) begin
         row_wdata[RowW-1 -: 32] = ver_new;
         if (hit_c) begin
            row_we = 1'b1;
            row_wdata[fway*MetaW + 70 +: 64] = stamp_ff;
         end else if (ins_ok) begin
            row_we = 1'b1;
            val_we = 1'b1;
            row_wdata[sel*MetaW +: 64]      = key_ff;
            row_wdata[sel*MetaW + 64]       = 1'b0;
            row_wdata[sel*MetaW + 65]       = 1'b0;
            row_wdata[sel*MetaW + 66 +: 4]  = vlen_ff;
            row_wdata[sel*MetaW + 70 +: 64] = stamp_ff + 64'd1;
            val_wdata[sel*64 +: 64] = vin_ff & kvc_pkg::byte_mask(vlen_ff);
         end else if (bump) begin
            row_we = 1'b1;
            if (op == kvc_pkg::OP_STALE) begin
               row_wdata[fway*MetaW + 65] = 1'b1;
            end else begin
               row_wdata[fway*MetaW +: 64]     = '0;
               row_wdata[fway*MetaW + 64]      = 1'b1;
               row_wdata[fway*MetaW + 65]      = 1'b0;
               row_wdata[fway*MetaW + 66 +: 4] = 4'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_hit            <= hit_c;
         rsp_length_out     <= hit_c ? sz : 4'd0;
         rsp_value_out      <= hit_c ? (val_rdata[fway*64 +: 64] &
                                        kvc_pkg::byte_mask(sz)) : 64'd0;
         rsp_bucket_version <= ver_new;
         if (reserved || (op == kvc_pkg::OP_INSERT && !ins_ok))
            rsp_status <= kvc_pkg::ST_REJECT;
         else if (op == kvc_pkg::OP_INSERT || (found && !(op == kvc_pkg::OP_LOOKUP
                  && wstale[fway])))
            rsp_status <= kvc_pkg::ST_DONE;
         else
            rsp_status <= kvc_pkg::ST_NOTFOUND;
      end
   end
endmodule

`default_nettype wire

>>> hw/rtl/kv_cache_bucket_lru_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kv_cache_bucket_lru_top
// Hashed set-associative key-value cache with oldest-stamp replacement.
//
//  channel  dir  accept           payload
//  req      in   valid & ready    operation key value_in value_length read_capacity
//  rsp      out  valid & ready    hit value_out length_out status bucket_version
//
// Each item passes through accept, 8 byte rounds of the FNV hash
// (shift-and-add by the prime) and a step to settle the bucket index,
// then bucket row read, decide and write-back, and the response.
// One item is in flight; req is not ready until the response is taken.
// After reset a clearing pass zeroes every bucket row before req is ready.
// ----------------------------------------------------------------------------
module kv_cache_bucket_lru_top #(
   parameter int unsigned NumBuckets = kvc_pkg::NumBucketsDefault,
   parameter int unsigned Ways       = kvc_pkg::WaysDefault,
   parameter int unsigned ValueBytes = kvc_pkg::ValueBytesDefault
) (
   input  wire    clock,
   input  wire    reset,
   kvc_req_if.sink   req,
   kvc_rsp_if.source rsp
);
   kvc_pkg::cmd_type cmd;
   kvc_pkg::sts_type sts;

   kvc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd));

   kvc_dp #(.NumBuckets(NumBuckets), .Ways(Ways), .ValueBytes(ValueBytes)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_operation(req.operation), .req_key(req.key),
      .req_value_in(req.value_in), .req_value_length(req.value_length),
      .req_read_capacity(req.read_capacity),
      .rsp_hit(rsp.hit), .rsp_value_out(rsp.value_out),
      .rsp_length_out(rsp.length_out), .rsp_status(rsp.status),
      .rsp_bucket_version(rsp.bucket_version));
endmodule

`default_nettype wire

>>> dv/kv_cache_bucket_lru_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// kv_cache_bucket_lru_top_test
// Self-checking bench for the bucketed key-value cache. A behavioral copy of
// the cache predicts every response; responses are compared field by field
// in order. Stimulus covers reserved keys, bad lengths, stale and evicted
// entries, replacement in full buckets and random traffic on a small key set.
// ----------------------------------------------------------------------------
module kv_cache_bucket_lru_top_test;

   localparam int Buckets  = kvc_pkg::NumBucketsDefault;
   localparam int NWays    = kvc_pkg::WaysDefault;
   localparam int VBytes   = kvc_pkg::ValueBytesDefault;
   localparam int MaxCycle = 400000;

   typedef struct packed {
      logic                 hit;
      logic [63:0]          value_out;
      logic [3:0]           length_out;
      kvc_pkg::status_type  status;
      logic [31:0]          bucket_version;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kvc_req_if req ();
   kvc_rsp_if rsp ();

   kv_cache_bucket_lru_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cache shadow state
   logic [63:0] way_key    [Buckets*NWays];
   logic        way_tomb   [Buckets*NWays];
   logic        way_stale  [Buckets*NWays];
   logic [3:0]  way_len    [Buckets*NWays];
   logic [63:0] way_val    [Buckets*NWays];
   logic [63:0] way_stamp  [Buckets*NWays];
   logic [31:0] bucket_ver [Buckets];
   logic [63:0] stamp_now;

   rsp_item_type pending_rsp[$];
   logic [63:0]  key_pool[$];
   int           err_count  = 0;
   int           rsp_count  = 0;
   int           hit_count  = 0;
   int           cycle_count = 0;
   bit           rsp_stall_en = 1'b1;

   function automatic int bucket_of(input logic [63:0] k);
      logic [63:0] h;
      h = kvc_pkg::FnvBasis;
      for (int i = 0; i < 8; i++) begin
         h = h ^ {56'd0, k[8*i +: 8]};
         h = h * kvc_pkg::FnvPrime;
      end
      return int'(h % Buckets);
   endfunction

   function automatic logic [63:0] low_bytes(input logic [63:0] v, input int n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) if (n > i) m[8*i +: 8] = 8'hff;
      return v & m;
   endfunction

   // Apply one item to the shadow cache and return the predicted response
   function automatic rsp_item_type cache_apply(input kvc_pkg::op_type op,
                                                input logic [63:0] k,
                                                input logic [63:0] vin,
                                                input logic [3:0] vlen,
                                                input logic [3:0] cap);
      rsp_item_type r;
      int b, base, w, e, match, freew, lru, sz;
      logic [63:0] lru_stamp;
      r = '0;
      r.status = kvc_pkg::ST_DONE;
      b = bucket_of(k);
      base = b * NWays;
      w = -1;
      for (int i = NWays - 1; i >= 0; i--)
         if (!way_tomb[base+i] && way_key[base+i] == k) w = i;
      if (k == 64'd0 || k == kvc_pkg::KeyOnes) begin
         r.status = kvc_pkg::ST_REJECT;
      end else if (op == kvc_pkg::OP_LOOKUP) begin
         if (w < 0 || way_stale[base+w]) begin
            r.status = kvc_pkg::ST_NOTFOUND;
         end else begin
            e = base + w;
            sz = (way_len[e] > cap) ? cap : way_len[e];
            r.hit = 1'b1;
            r.length_out = 4'(sz);
            r.value_out = low_bytes(way_val[e], sz);
            way_stamp[e] = stamp_now;
         end
      end else if (op == kvc_pkg::OP_INSERT) begin
         if (vlen > VBytes) begin
            r.status = kvc_pkg::ST_REJECT;
         end else begin
            match = -1; freew = -1; lru = 0;
            lru_stamp = way_stamp[base];
            for (int i = 0; i < NWays; i++) begin
               e = base + i;
               if (!way_tomb[e] && way_key[e] == k) begin
                  match = i;
                  break;
               end
               if (freew < 0 && (way_tomb[e] || way_key[e] == 64'd0)) freew = i;
               if (way_stamp[e] < lru_stamp) begin
                  lru_stamp = way_stamp[e];
                  lru = i;
               end
            end
            w = (match >= 0) ? match : ((freew >= 0) ? freew : lru);
            e = base + w;
            way_len[e] = vlen;
            way_val[e] = low_bytes(vin, vlen);
            stamp_now = stamp_now + 64'd1;
            way_stamp[e] = stamp_now;
            way_stale[e] = 1'b0;
            way_tomb[e] = 1'b0;
            way_key[e] = k;
            bucket_ver[b] = bucket_ver[b] + 32'd1;
         end
      end else begin
         if (w < 0) begin
            r.status = kvc_pkg::ST_NOTFOUND;
         end else begin
            e = base + w;
            if (op == kvc_pkg::OP_STALE) begin
               way_stale[e] = 1'b1;
            end else begin
               way_tomb[e] = 1'b1;
               way_key[e] = 64'd0;
               way_stale[e] = 1'b0;
               way_len[e] = 4'd0;
            end
            bucket_ver[b] = bucket_ver[b] + 32'd1;
         end
      end
      r.bucket_version = bucket_ver[b];
      return r;
   endfunction

   // Send one item; the prediction is made when it is accepted.
   // valid stays high afterwards until the next item or an idle stretch.
   task automatic send_item(input kvc_pkg::op_type op, input logic [63:0] k,
                            input logic [63:0] vin, input logic [3:0] vlen,
                            input logic [3:0] cap);
      req.valid         <= 1'b1;
      req.operation     <= op;
      req.key           <= k;
      req.value_in      <= vin;
      req.value_length  <= vlen;
      req.read_capacity <= cap;
      do @(posedge clock); while (!req.ready);
      pending_rsp.push_back(cache_apply(op, k, vin, vlen, cap));
   endtask

   task automatic idle_cycles(input int n);
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      idle_cycles(1);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Keys that share one bucket, to force replacement
   task automatic find_same_bucket(input int n, output logic [63:0] ks[$]);
      logic [63:0] k;
      int b;
      ks = {};
      k = rand64() | 64'd1;
      b = bucket_of(k);
      ks.push_back(k);
      while (ks.size() < n) begin
         k = rand64();
         if (k != 64'd0 && k != kvc_pkg::KeyOnes && bucket_of(k) == b) ks.push_back(k);
      end
   endtask

   // Response checker with its own stall pattern
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.hit = rsp.hit;
            got.value_out = rsp.value_out;
            got.length_out = rsp.length_out;
            got.status = kvc_pkg::status_type'(rsp.status);
            got.bucket_version = rsp.bucket_version;
            rsp_count++;
            if (got.hit) hit_count++;
            if (pending_rsp.size() == 0) begin
               err_count++;
               $display("%0t: unexpected response %p", $time, got);
            end else begin
               want = pending_rsp.pop_front();
               if (got.hit !== want.hit) begin
                  err_count++;
                  $display("%0t: hit exp %0b got %0b", $time, want.hit, got.hit);
               end
               if (got.value_out !== want.value_out) begin
                  err_count++;
                  $display("%0t: value_out exp %h got %h", $time, want.value_out,
                           got.value_out);
               end
               if (got.length_out !== want.length_out) begin
                  err_count++;
                  $display("%0t: length_out exp %0d got %0d", $time,
                           want.length_out, got.length_out);
               end
               if (got.status !== want.status) begin
                  err_count++;
                  $display("%0t: status exp %0d got %0d", $time, want.status,
                           got.status);
               end
               if (got.bucket_version !== want.bucket_version) begin
                  err_count++;
                  $display("%0t: bucket_version exp %0d got %0d", $time,
                           want.bucket_version, got.bucket_version);
               end
            end
         end
         // stall pattern: long free stretches, then random stalls
         if (!rsp_stall_en || cycle_count % 512 < 128) rsp.ready <= 1'b1;
         else rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MaxCycle) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Reserved keys, length limits and every operation on one key
   task automatic test_directed();
      logic [63:0] k;
      k = 64'h0123_4567_89ab_cdef;
      send_item(kvc_pkg::OP_INSERT, 64'd0, kvc_pkg::KeyOnes, 4'd8, 4'd8);
      send_item(kvc_pkg::OP_LOOKUP, kvc_pkg::KeyOnes, 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_STALE, 64'd0, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_EVICT, kvc_pkg::KeyOnes, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_STALE, k, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_EVICT, k, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_INSERT, k, kvc_pkg::KeyOnes, 4'd15, 4'd0);
      send_item(kvc_pkg::OP_INSERT, k, kvc_pkg::KeyOnes, 4'd9, 4'd0);
      send_item(kvc_pkg::OP_INSERT, k, kvc_pkg::KeyOnes, 4'd8, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd3);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_INSERT, k, 64'hfedc_ba98_7654_3210, 4'd3, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd15);
      send_item(kvc_pkg::OP_INSERT, k, 64'hfedc_ba98_7654_3210, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_STALE, k, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_INSERT, k, 64'h1122_3344_5566_7788, 4'd5, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_EVICT, k, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, k, 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_EVICT, k, 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_INSERT, kvc_pkg::KeyOnes - 64'd1, 64'd1, 4'd1, 4'd0);
   endtask

   // Overfill one bucket: recency order, ties, tombstone reuse
   task automatic test_replacement();
      logic [63:0] ks[$];
      find_same_bucket(NWays + 3, ks);
      for (int i = 0; i < NWays; i++)
         send_item(kvc_pkg::OP_INSERT, ks[i], rand64(), 4'd8, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, ks[0], 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_INSERT, ks[NWays], rand64(), 4'd4, 4'd0);
      send_item(kvc_pkg::OP_LOOKUP, ks[1], 64'd0, 4'd0, 4'd8);
      send_item(kvc_pkg::OP_EVICT, ks[2], 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_INSERT, ks[NWays+1], rand64(), 4'd7, 4'd0);
      send_item(kvc_pkg::OP_STALE, ks[3], 64'd0, 4'd0, 4'd0);
      send_item(kvc_pkg::OP_INSERT, ks[NWays+2], rand64(), 4'd2, 4'd0);
      foreach (ks[i]) send_item(kvc_pkg::OP_LOOKUP, ks[i], 64'd0, 4'd0, 4'd8);
      foreach (ks[i]) key_pool.push_back(ks[i]);
   endtask

   // Random traffic on a small key pool, bursts with random gaps
   task automatic test_random(input int n_items);
      logic [63:0]     ks[$];
      logic [63:0]     k;
      kvc_pkg::op_type op;
      int              burst;
      for (int g = 0; g < 6; g++) begin
         find_same_bucket(NWays + 2, ks);
         foreach (ks[i]) key_pool.push_back(ks[i]);
      end
      burst = 0;
      for (int i = 0; i < n_items; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 20));
         end
         burst--;
         case ($urandom_range(0, 19))
            0:       k = 64'd0;
            1:       k = kvc_pkg::KeyOnes;
            2, 3:    k = rand64();
            default: k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = kvc_pkg::OP_INSERT;
            4, 5, 6:    op = kvc_pkg::OP_LOOKUP;
            7, 8:       op = kvc_pkg::OP_STALE;
            default:    op = kvc_pkg::OP_EVICT;
         endcase
         send_item(op, k, rand64(),
                   4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 8)),
                   4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 8)));
      end
   endtask

   initial begin
      for (int i = 0; i < Buckets * NWays; i++) begin
         way_key[i] = '0; way_tomb[i] = 1'b0; way_stale[i] = 1'b0;
         way_len[i] = '0; way_val[i] = '0; way_stamp[i] = '0;
      end
      for (int i = 0; i < Buckets; i++) bucket_ver[i] = '0;
      stamp_now = '0;
      req.operation <= kvc_pkg::OP_LOOKUP;
      req.key <= '0;
      req.value_in <= '0;
      req.value_length <= '0;
      req.read_capacity <= '0;
      idle_cycles(5);
      reset <= 1'b0;

      test_directed();
      test_replacement();
      test_random(600);

      wait_drained();
      idle_cycles(40);
      $display("Covered %0d responses (%0d lookup hits) incl. reserved keys,", rsp_count,
               hit_count);
      $display("bad lengths, stale/evicted entries and full-bucket replacement.");
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> kv_cache_bucket_lru_top.f
hw/rtl/kvc_pkg.sv
hw/rtl/kvc_if.sv
hw/rtl/kvc_ram.sv
hw/rtl/kvc_ctrl.sv
hw/rtl/kvc_dp.sv
hw/rtl/kv_cache_bucket_lru_top.sv
dv/kv_cache_bucket_lru_top_test.sv
